@@ rtl/itcl_pkg.sv @@
// Shared types and constants for the interval table cursor lookup.
// No dependencies; imported by itcl_table and interval_table_cursor_lookup.
`default_nettype none

package itcl_pkg;

    // Table geometry
    localparam int TABLE_DEPTH = 1024;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int FRAME_W     = 32;
    localparam int ENTRY_W     = 10;

    typedef logic [IDX_W-1:0]   t_idx;
    typedef logic [FRAME_W-1:0] t_frame;

    // Last index that may hold an entry
    localparam t_idx LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

    // Mode codes
    localparam logic [1:0] MODE_CLEAR  = 2'd0;
    localparam logic [1:0] MODE_APPEND = 2'd1;
    localparam logic [1:0] MODE_QUERY  = 2'd2;

    // Status codes
    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    typedef struct packed {
        logic [1:0] mode;
        t_frame     start_value;
        t_frame     end_value;
        t_frame     query_frame;
    } t_in_item;

    typedef struct packed {
        logic               found;
        logic [ENTRY_W-1:0] entry_index;
        logic               status;
    } t_out_item;

    // Table read request: one address per memory
    typedef struct packed {
        logic en;
        t_idx addr_s;
        t_idx addr_e;
    } t_tbl_rd;

    // Table write request: both memories at one address
    typedef struct packed {
        logic   en;
        t_idx   addr;
        t_frame start_v;
        t_frame end_v;
    } t_tbl_wr;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHK,
        S_DIR,
        S_FWD,
        S_BWD,
        S_APP,
        S_HOLD
    } t_state;

endpackage

`default_nettype wire

@@ rtl/interval_table_cursor_lookup.sv @@
// Top level of the interval table cursor lookup: sequencer, cursor and output register.
// Depends on itcl_pkg and itcl_table.
//
//  Channel | Valid       | Ready       | Payload
//  --------+-------------+-------------+--------------------------
//  input   | i_in_valid  | o_in_ready  | i_in_item  (t_in_item)
//  result  | o_out_valid | i_out_ready | o_out_item (t_out_item)
//
// One item at a time. Clear, unused mode and a dropped append finish in S_IDLE; an append
// reads the previous end and writes in S_APP. A query checks the cursor entry in S_CHK,
// else reads both neighbors, picks a direction or finishes in S_DIR and walks in S_FWD or S_BWD;
// each walk step is one registered read of both table memories.
// Reset clears entry count, cursor and handshake state; no clearing pass,
// entry 0 reads as zero and entries above the count are never read.
// A result waiting on i_out_ready holds the sequencer in S_HOLD only when
// a second result is finished; the next item is taken while one waits.
`default_nettype none

module interval_table_cursor_lookup (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    output logic                 o_in_ready,
    input  itcl_pkg::t_in_item   i_in_item,
    output logic                 o_out_valid,
    input  wire                  i_out_ready,
    output itcl_pkg::t_out_item  o_out_item
);
    import itcl_pkg::*;

    t_state    r_state, n_state;
    t_idx      r_count, n_count;
    t_idx      r_cursor, n_cursor;
    t_idx      r_cur, n_cur;
    t_in_item  r_item, n_item;
    t_out_item r_res, n_res_hold;
    logic      r_out_valid, n_out_valid;
    t_out_item r_out, n_out;

    t_tbl_rd   rd;
    t_tbl_wr   wr;
    t_frame    rd_start;
    t_frame    rd_end;

    logic      fin;
    t_out_item res;
    logic      slot_free;
    logic      accept;
    t_idx      cur_clamp;
    t_idx      step;
    logic      has_next;
    logic      has_prev;
    t_frame    adj_start;

    itcl_table u_table (
        .i_clk   (i_clk),
        .i_rd    (rd),
        .i_wr    (wr),
        .o_start (rd_start),
        .o_end   (rd_end)
    );

    assign o_in_ready  = (r_state == S_IDLE);
    assign accept      = i_in_valid && o_in_ready;
    assign slot_free   = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    assign cur_clamp = (r_cursor > r_count) ? r_count : r_cursor;
    assign has_next  = (r_cur < r_count);
    assign has_prev  = (r_cur != '0);
    assign adj_start = (r_item.start_value <= rd_end) ? rd_end + 1'b1 : r_item.start_value;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_cursor    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_cursor    <= n_cursor;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_cur  <= n_cur;
        r_item <= n_item;
        r_res  <= n_res_hold;
        r_out  <= n_out;
    end

    // Sequencer: next state, table accesses and result
    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_cursor = r_cursor;
        n_cur    = r_cur;
        n_item   = r_item;
        rd       = '{en: 1'b0, addr_s: r_cur, addr_e: r_cur};
        wr       = '{en: 1'b0, addr: r_count + 1'b1, start_v: adj_start,
                     end_v: r_item.end_value};
        fin      = 1'b0;
        res      = '0;
        step     = r_cur;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_item = i_in_item;
                    case (i_in_item.mode)
                        MODE_CLEAR: begin
                            n_count  = '0;
                            n_cursor = '0;
                            fin      = 1'b1;
                        end
                        MODE_APPEND: begin
                            if (r_count == LAST_IDX) begin
                                fin        = 1'b1;
                                res.status = STATUS_FULL;
                            end else begin
                                rd      = '{en: 1'b1, addr_s: r_count, addr_e: r_count};
                                n_state = S_APP;
                            end
                        end
                        MODE_QUERY: begin
                            n_cur    = cur_clamp;
                            n_cursor = cur_clamp;
                            rd       = '{en: 1'b1, addr_s: cur_clamp, addr_e: cur_clamp};
                            n_state  = S_CHK;
                        end
                        default: begin
                            fin = 1'b1;
                        end
                    endcase
                end
            end

            // Append: previous end is in rd_end; write the next slot
            S_APP: begin
                wr.en           = 1'b1;
                n_count         = r_count + 1'b1;
                fin             = 1'b1;
                res.entry_index = ENTRY_W'(r_count + 1'b1);
            end

            // Cursor entry check; fetch both neighbors for the direction choice
            S_CHK: begin
                if (rd_start <= r_item.query_frame && rd_end >= r_item.query_frame) begin
                    fin             = 1'b1;
                    res.found       = 1'b1;
                    res.entry_index = ENTRY_W'(r_cur);
                end else begin
                    rd.en     = 1'b1;
                    rd.addr_s = has_next ? r_cur + 1'b1 : r_cur;
                    rd.addr_e = has_prev ? r_cur - 1'b1 : r_cur;
                    n_state   = S_DIR;
                end
            end

            // Choose walk direction
            S_DIR: begin
                if (has_next && rd_start <= r_item.query_frame) begin
                    rd      = '{en: 1'b1, addr_s: r_cur + 1'b1, addr_e: r_cur + 1'b1};
                    n_state = S_FWD;
                end else if (has_prev && rd_end >= r_item.query_frame) begin
                    rd      = '{en: 1'b1, addr_s: r_cur - 1'b1, addr_e: r_cur - 1'b1};
                    n_state = S_BWD;
                end else begin
                    fin = 1'b1;
                end
            end

            // Forward walk: table data is for entry r_cur + 1
            S_FWD: begin
                step = r_cur + 1'b1;
                if (rd_start > r_item.query_frame) begin
                    fin = 1'b1;
                end else begin
                    n_cur    = step;
                    n_cursor = step;
                    if (rd_end >= r_item.query_frame) begin
                        fin             = 1'b1;
                        res.found       = 1'b1;
                        res.entry_index = ENTRY_W'(step);
                    end else if (step < r_count) begin
                        rd = '{en: 1'b1, addr_s: step + 1'b1, addr_e: step + 1'b1};
                    end else begin
                        fin = 1'b1;
                    end
                end
            end

            // Backward walk: table data is for entry r_cur - 1
            S_BWD: begin
                step = r_cur - 1'b1;
                if (rd_end < r_item.query_frame) begin
                    fin = 1'b1;
                end else begin
                    n_cur    = step;
                    n_cursor = step;
                    if (rd_start <= r_item.query_frame) begin
                        fin             = 1'b1;
                        res.found       = 1'b1;
                        res.entry_index = ENTRY_W'(step);
                    end else if (step != '0) begin
                        rd = '{en: 1'b1, addr_s: step - 1'b1, addr_e: step - 1'b1};
                    end else begin
                        fin = 1'b1;
                    end
                end
            end

            // Finished result waits for the output register
            S_HOLD: begin
                if (slot_free) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (fin) begin
            n_state = slot_free ? S_IDLE : S_HOLD;
        end
    end

    // Output register and holding register for a blocked result
    always_comb begin
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        n_res_hold  = r_res;
        if (r_state == S_HOLD) begin
            if (slot_free) begin
                n_out_valid = 1'b1;
                n_out       = r_res;
            end
        end else if (fin) begin
            if (slot_free) begin
                n_out_valid = 1'b1;
                n_out       = res;
            end else begin
                n_res_hold = res;
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/itcl_table.sv @@
// Start and end frame memories, one synchronous read port each, one shared write port.
// Entry 0 is the fixed dummy [0,0] and reads as zero. Depends on itcl_pkg.
`default_nettype none

module itcl_table (
    input  wire              i_clk,
    input  itcl_pkg::t_tbl_rd i_rd,
    input  itcl_pkg::t_tbl_wr i_wr,
    output itcl_pkg::t_frame  o_start,
    output itcl_pkg::t_frame  o_end
);
    import itcl_pkg::*;

    t_frame start_mem [TABLE_DEPTH];
    t_frame end_mem   [TABLE_DEPTH];

    t_frame r_rd_s;
    t_frame r_rd_e;
    logic   r_zero_s;
    logic   r_zero_e;

    // Write port: appends only, never entry 0
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            start_mem[i_wr.addr] <= i_wr.start_v;
            end_mem[i_wr.addr]   <= i_wr.end_v;
        end
    end

    // Registered reads; remember whether the dummy entry was addressed
    always_ff @(posedge i_clk) begin
        if (i_rd.en) begin
            r_rd_s   <= start_mem[i_rd.addr_s];
            r_rd_e   <= end_mem[i_rd.addr_e];
            r_zero_s <= (i_rd.addr_s == '0);
            r_zero_e <= (i_rd.addr_e == '0);
        end
    end

    assign o_start = r_zero_s ? '0 : r_rd_s;
    assign o_end   = r_zero_e ? '0 : r_rd_e;

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
// Testbench for interval_table_cursor_lookup: a shadow copy of the interval table
// checks every result. Depends on itcl_pkg and the RTL of the block.
`timescale 1ns / 1ps

module testbench;
    import itcl_pkg::*;

    // Mode 3 is not decoded by the block
    localparam logic [1:0] MODE_UNUSED  = 2'd3;
    localparam int         CLK_PERIOD   = 10;
    localparam int         STALL_LIMIT  = 20000;
    localparam int         DRAIN_CYCLES = 40;
    localparam int         PHASE_ITEMS  = 85;

    // Shadow of the table and cursor; queues the answer for each accepted item
    class table_shadow;
        t_frame    starts[TABLE_DEPTH];
        t_frame    ends[TABLE_DEPTH];
        t_idx      count;
        t_idx      cur;
        t_out_item due_answers[$];
        int        mismatch_count;

        function new();
            count          = '0;
            cur            = '0;
            starts[0]      = '0;
            ends[0]        = '0;
            mismatch_count = 0;
        endfunction

        function bit covers(t_idx k, t_frame fr);
            return starts[k] <= fr && ends[k] >= fr;
        endfunction

        function t_out_item answer_for(t_in_item it);
            t_out_item r;
            t_idx      c;
            t_frame    sv;
            t_frame    fr;
            bit        hit;
            r   = '0;
            hit = 1'b0;
            fr  = it.query_frame;
            case (it.mode)
                MODE_CLEAR: begin
                    count     = '0;
                    cur       = '0;
                    starts[0] = '0;
                    ends[0]   = '0;
                end
                MODE_APPEND: begin
                    if (count >= LAST_IDX) begin
                        r.status = STATUS_FULL;
                    end else begin
                        // overlapping start is pushed past the previous end (wraps at all ones)
                        sv = it.start_value;
                        if (sv <= ends[count])
                            sv = ends[count] + t_frame'(1);
                        count         = count + t_idx'(1);
                        starts[count] = sv;
                        ends[count]   = it.end_value;
                        r.entry_index = count;
                    end
                end
                MODE_QUERY: begin
                    c   = (cur > count) ? count : cur;
                    cur = c;
                    if (covers(c, fr)) begin
                        hit = 1'b1;
                    end else if (c < count && starts[c + t_idx'(1)] <= fr) begin
                        // forward walk while the next entry starts at or before the frame
                        while (!hit && c < count && starts[c + t_idx'(1)] <= fr) begin
                            c   = c + t_idx'(1);
                            cur = c;
                            hit = covers(c, fr);
                        end
                    end else if (c > 0 && ends[c - t_idx'(1)] >= fr) begin
                        // backward walk while the previous entry ends at or after the frame
                        while (!hit && c > 0 && ends[c - t_idx'(1)] >= fr) begin
                            c   = c - t_idx'(1);
                            cur = c;
                            hit = covers(c, fr);
                        end
                    end
                    if (hit) begin
                        r.found       = 1'b1;
                        r.entry_index = c;
                    end
                end
                default: ;
            endcase
            return r;
        endfunction

        function void note_request(t_in_item it);
            due_answers.push_back(answer_for(it));
        endfunction

        task report(string what);
            $display("%0t: result mismatch: %s", $time, what);
            mismatch_count++;
        endtask

        task check_answer(t_out_item got);
            t_out_item want;
            if (due_answers.size() == 0) begin
                report($sformatf("result %h with no item outstanding", got));
                return;
            end
            want = due_answers.pop_front();
            if (got.found !== want.found)
                report($sformatf("found %b, want %b", got.found, want.found));
            if (got.entry_index !== want.entry_index)
                report($sformatf("entry_index %0d, want %0d", got.entry_index, want.entry_index));
            if (got.status !== want.status)
                report($sformatf("status %b, want %b", got.status, want.status));
        endtask
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    t_in_item    i_in_item;
    logic        o_out_valid;
    logic        i_out_ready;
    t_out_item   o_out_item;

    table_shadow shadow;
    int          tx_idle_pct;
    int          rx_idle_pct;

    interval_table_cursor_lookup i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Result side stalls at random
    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // Both channels sampled at the rising edge
    always @(posedge i_clk) begin : monitor
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready)
                shadow.note_request(i_in_item);
            if (o_out_valid && i_out_ready)
                shadow.check_answer(o_out_item);
        end
    end

    // Ends the run when nothing moves for too long
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("interval_table_cursor_lookup test failed");
        $finish;
    end

    function automatic t_in_item make_item(logic [1:0] m, t_frame s, t_frame e, t_frame f);
        t_in_item it;
        it.mode        = m;
        it.start_value = s;
        it.end_value   = e;
        it.query_frame = f;
        return it;
    endfunction

    // Mostly ordered intervals after the last one; some overlap, inverted, end or start at all ones
    function automatic t_in_item make_append();
        t_frame s;
        t_frame e;
        int     r;
        s = shadow.ends[shadow.count] + t_frame'(1 + $urandom_range(4));
        if (shadow.count == 0 && $urandom_range(1) == 1)
            s = $urandom;
        e = s + t_frame'($urandom_range(40));
        r = $urandom_range(99);
        if (r < 8) begin
            s = $urandom;
        end else if (r < 14) begin
            e = s - t_frame'(1 + $urandom_range(9));
        end else if (r < 17) begin
            e = '1;
        end else if (r < 20) begin
            s = '1;
            e = $urandom;
        end
        return make_item(MODE_APPEND, s, e, $urandom);
    endfunction

    // Frames mostly near the cursor, some anywhere in the table, in gaps or at the extremes
    function automatic t_in_item make_query();
        t_idx   n;
        int     k;
        int     r;
        t_frame lo;
        t_frame hi;
        t_frame fr;
        n = shadow.count;
        if ($urandom_range(99) < 60)
            k = int'(shadow.cur) + int'($urandom_range(5)) - 2;
        else
            k = int'($urandom_range(n));
        if (k < 0)
            k = 0;
        if (k > int'(n))
            k = int'(n);
        lo = shadow.starts[k];
        hi = shadow.ends[k];
        r  = $urandom_range(99);
        if (r < 65 && lo <= hi)
            fr = lo + t_frame'($urandom_range(hi - lo));
        else if (r < 75)
            fr = lo - t_frame'(1);
        else if (r < 85)
            fr = hi + t_frame'(1);
        else if (r < 92)
            fr = ($urandom_range(1) == 1) ? '1 : '0;
        else
            fr = $urandom;
        return make_item(MODE_QUERY, $urandom, $urandom, fr);
    endfunction

    // Entered at a falling edge, returns at the falling edge after acceptance
    task automatic send_item(t_in_item it);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        do
            @(posedge i_clk);
        while (!(i_in_valid && o_in_ready));
        @(negedge i_clk);
    endtask

    task automatic run_directed();
        // dummy entry and an empty table
        send_item(make_item(MODE_QUERY, '0, '0, '0));
        send_item(make_item(MODE_QUERY, '1, '1, 32'd1));
        // overlap, inverted entry, end at all ones, then a start that wraps to zero
        send_item(make_item(MODE_APPEND, 32'd10, 32'd20, '0));
        send_item(make_item(MODE_APPEND, 32'd5, 32'd30, '0));
        send_item(make_item(MODE_APPEND, 32'd100, 32'd50, '1));
        send_item(make_item(MODE_APPEND, 32'hFFFF_FFF0, '1, '0));
        send_item(make_item(MODE_APPEND, 32'd3, 32'd7, '0));
        // forward walks, misses, a walk back to the dummy, more forward walks, a cursor hit, a backward walk
        send_item(make_item(MODE_QUERY, '0, '0, 32'd15));
        send_item(make_item(MODE_QUERY, '0, '0, 32'd25));
        send_item(make_item(MODE_QUERY, '0, '0, 32'd60));
        send_item(make_item(MODE_QUERY, '0, '0, 32'd75));
        send_item(make_item(MODE_QUERY, '1, '1, '0));
        send_item(make_item(MODE_QUERY, '0, '0, '1));
        send_item(make_item(MODE_QUERY, '0, '0, 32'd5));
        send_item(make_item(MODE_QUERY, '0, '0, 32'd5));
        send_item(make_item(MODE_QUERY, '0, '0, 32'd21));
        // unused mode changes nothing
        send_item(make_item(MODE_UNUSED, '1, '1, '1));
        send_item(make_item(MODE_UNUSED, '0, '0, '0));
        send_item(make_item(MODE_CLEAR, '1, '1, '1));
        send_item(make_item(MODE_QUERY, '0, '0, '0));
        send_item(make_item(MODE_APPEND, '1, '0, '0));
        send_item(make_item(MODE_QUERY, '0, '0, '1));
        send_item(make_item(MODE_APPEND, '0, '0, '0));
        send_item(make_item(MODE_QUERY, '0, '0, '0));
    endtask

    task automatic random_phase(int target);
        int r;
        for (int n = 0; n < target; n++) begin
            r = $urandom_range(99);
            if (r < 3)
                send_item(make_item(MODE_CLEAR, $urandom, $urandom, $urandom));
            else if (r < 8)
                send_item(make_item(2'($urandom_range(3)), $urandom, $urandom, $urandom));
            else if (r < 38)
                send_item(make_append());
            else
                send_item(make_query());
        end
    endtask

    // Fill the table to the top, run past it, then query across the full table
    task automatic fill_table();
        send_item(make_item(MODE_CLEAR, $urandom, $urandom, $urandom));
        for (int n = 0; n < TABLE_DEPTH + 8; n++) begin
            send_item(make_append());
            if ($urandom_range(31) == 0)
                send_item(make_query());
        end
        repeat (40) send_item(make_query());
    endtask

    initial begin
        i_clk       = 1'b0;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_item   = '0;
        i_out_ready = 1'b0;
        tx_idle_pct = 24;
        rx_idle_pct = 62;
        shadow      = new();

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        run_directed();
        random_phase(PHASE_ITEMS);
        tx_idle_pct = 62;
        rx_idle_pct = 24;
        random_phase(PHASE_ITEMS);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        fill_table();
        random_phase(100);
        i_in_valid <= 1'b0;

        // drain, then watch for stray results
        while (shadow.due_answers.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (shadow.mismatch_count == 0)
            $display("interval_table_cursor_lookup test passed");
        else
            $display("interval_table_cursor_lookup test failed");
        $finish;
    end

endmodule

@@ files.f @@
rtl/itcl_pkg.sv
rtl/itcl_table.sv
rtl/interval_table_cursor_lookup.sv
tb/testbench.sv
